### rtl/core/cep_pkg.sv
// ============================================================================
// cep_pkg
// Shared types and constants of the cubic ease servo motion profiler.
// ============================================================================
package cep_pkg;

    localparam int FIELD_JOINTS = 5;
    localparam int ANGLE_W      = 8;
    localparam int MSPD_W       = 8;
    localparam int TOTAL_W      = 16;   // |distance| * ms-per-degree
    localparam int CUBE_W       = 48;   // TOTAL_W cubed
    localparam int NUM_W        = 58;   // cube times 4 * |distance|
    localparam int QUO_W        = 8;
    localparam int CFG_INDEX_W  = 3;
    localparam int MUL_A_W      = 48;
    localparam int MUL_B_W      = 16;

    localparam logic [MSPD_W-1:0] MSPD_RESET = 8'd10;

    typedef enum logic [1:0] {
        ACT_UPDATE  = 2'd0,
        ACT_SET_ALL = 2'd1,
        ACT_SET_ONE = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    typedef struct packed {
        logic                 start;
        logic [TOTAL_W-1:0]   total;
        logic [TOTAL_W-1:0]   x;
        logic [ANGLE_W-1:0]   cmag;
    } ease_req_t;

    typedef struct packed {
        logic                 done;
        logic [QUO_W-1:0]     quo;
        logic                 rem_nz;
    } ease_rsp_t;

endpackage

### rtl/core/cubic_ease_servo_motion_profiler.sv
// ============================================================================
// cubic_ease_servo_motion_profiler
// Per-joint cubic ease-in-out motion profiler with one shared ease engine.
// ============================================================================
// A set-joint or no-op request goes from the apply step to the finish step; an
//   update or set-position request walks the joints: a joint at its target is
//   skipped, a finished one snaps, an eased one uses the shared engine (5 multiplies, 8 divide steps).
// Throughput: one request at a time; a stalled result holds the finish step,
//   and the next request is taken once the result register has loaded.
// Reset (aresetn low, synchronous): angles and targets go to HOME_ANGLE,
//   start times to zero, ms-per-degree registers to 10, no result pending.
module cubic_ease_servo_motion_profiler #(
    parameter int JOINTS     = 5,
    parameter int ANGLE_MAX  = 180,
    parameter int TIME_WIDTH = 32,
    parameter int HOME_ANGLE = 90
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request: tdata = now_ms[31:0], target_joint1..5[71:32] (8 each),
    //          joint_select[74:72], joint_angle[82:75], zero pad
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,
    input  logic [1:0]  s_tuser,   // action
    // result: tdata = angle_joint1..5[39:0] (8 each), moving[40], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,
    // ms-per-degree register writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cep_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [cep_pkg::MSPD_W-1:0]      cfg_data
);

    localparam int ACTIVE = (JOINTS < cep_pkg::FIELD_JOINTS) ? JOINTS : cep_pkg::FIELD_JOINTS;
    localparam int JW     = (JOINTS > 1) ? $clog2(JOINTS) : 1;
    localparam int AW     = cep_pkg::ANGLE_W;

    localparam logic [AW-1:0] HOME  = AW'(HOME_ANGLE);
    localparam logic [AW-1:0] AMAX  = AW'(ANGLE_MAX);
    localparam logic [JW-1:0] JLAST = JW'(ACTIVE - 1);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_APPLY  = 6'b000010,
        S_LOAD   = 6'b000100,
        S_EVAL   = 6'b001000,
        S_WAIT   = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    state_t state_reg;

    // per-joint state
    logic [AW-1:0]         cur_reg   [JOINTS];
    logic [AW-1:0]         tgt_reg   [JOINTS];
    logic [AW-1:0]         begin_reg [JOINTS];
    logic [TIME_WIDTH-1:0] t0_reg    [JOINTS];
    logic [cep_pkg::MSPD_W-1:0] mspd_reg [cep_pkg::FIELD_JOINTS];

    // latched request
    cep_pkg::action_t      act_reg;
    logic [TIME_WIDTH-1:0] now_reg;
    logic [AW-1:0]         new_tgt_reg [cep_pkg::FIELD_JOINTS];
    logic [2:0]            sel_reg;
    logic [AW-1:0]         ang_reg;

    // per-joint work registers
    logic [JW-1:0]              j_reg;
    logic                       neg_reg;
    logic                       lo_reg;
    logic [AW-1:0]              cmag_reg;
    logic [cep_pkg::TOTAL_W-1:0] total_reg;
    logic [TIME_WIDTH-1:0]      e_reg;

    logic                       m_tvalid_reg;
    logic [47:0]                m_tdata_reg;

    cep_pkg::ease_req_t ease_req;
    cep_pkg::ease_rsp_t ease_rsp;

    logic                       snap;
    logic [TIME_WIDTH:0]        e_twice;
    logic [AW:0]                ceil_q;
    logic [AW:0]                eased;
    logic                       sel_ok;
    logic [JW-1:0]              sel_idx;
    logic [AW-1:0]              ang_clamped;
    logic [40:0]                result;

    function automatic logic [AW-1:0] clamp_angle(input logic [AW-1:0] a);
        return (a > AMAX) ? AMAX : a;
    endfunction

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // done when total is zero or elapsed passes it
    assign snap    = (total_reg == '0) || (e_reg > TIME_WIDTH'(total_reg));
    assign e_twice = {e_reg, 1'b0};

    assign ease_req.start = (state_reg == S_EVAL) && !snap;
    assign ease_req.total = total_reg;
    assign ease_req.x     = (e_twice < (TIME_WIDTH+1)'(total_reg))
                          ? e_reg[cep_pkg::TOTAL_W-1:0]
                          : total_reg - e_reg[cep_pkg::TOTAL_W-1:0];
    assign ease_req.cmag  = cmag_reg;

    cep_ease_unit u_ease (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (ease_req),
        .rsp     (ease_rsp)
    );

    // floor toward minus infinity: where the quotient is subtracted, the ceiling is used
    assign ceil_q = {1'b0, ease_rsp.quo} + (AW+1)'(ease_rsp.rem_nz);
    always_comb begin
        if (lo_reg) begin
            eased = neg_reg ? ({1'b0, begin_reg[j_reg]} - ceil_q)
                            : ({1'b0, begin_reg[j_reg]} + {1'b0, ease_rsp.quo});
        end else begin
            eased = neg_reg ? ({1'b0, tgt_reg[j_reg]} + {1'b0, ease_rsp.quo})
                            : ({1'b0, tgt_reg[j_reg]} - ceil_q);
        end
    end

    assign sel_ok      = (sel_reg >= 3'd1) && (sel_reg <= 3'(ACTIVE));
    assign sel_idx     = JW'(sel_reg - 3'd1);
    assign ang_clamped = clamp_angle(ang_reg);

    // pack the result; joints past ACTIVE report zero
    always_comb begin
        result = '0;
        for (int i = 0; i < ACTIVE; i++) begin
            result[i*AW +: AW] = cur_reg[i];
            if (cur_reg[i] != tgt_reg[i]) begin
                result[40] = 1'b1;
            end
        end
    end

    // configuration registers; writes past the list drop
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < cep_pkg::FIELD_JOINTS; i++) begin
                mspd_reg[i] <= cep_pkg::MSPD_RESET;
            end
        end else if (cfg_valid && cfg_ready &&
                     cfg_index < cep_pkg::CFG_INDEX_W'(cep_pkg::FIELD_JOINTS)) begin
            mspd_reg[cfg_index] <= cfg_data;
        end
    end

    // capture the request
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            act_reg <= cep_pkg::action_t'(s_tuser);
            now_reg <= s_tdata[TIME_WIDTH-1:0];
            for (int i = 0; i < cep_pkg::FIELD_JOINTS; i++) begin
                new_tgt_reg[i] <= s_tdata[32 + i*AW +: AW];
            end
            sel_reg <= s_tdata[74:72];
            ang_reg <= s_tdata[82:75];
        end
    end

    // sequencer and joint state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            j_reg        <= '0;
            for (int i = 0; i < JOINTS; i++) begin
                cur_reg[i]   <= HOME;
                tgt_reg[i]   <= HOME;
                begin_reg[i] <= HOME;
                t0_reg[i]    <= '0;
            end
        end else begin
            // drop the taken result; the finish step drives valid itself
            if (m_tvalid_reg && m_tready && state_reg != S_FINISH) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= S_APPLY;
                    end
                end
                S_APPLY: begin
                    j_reg <= '0;
                    unique case (act_reg)
                        cep_pkg::ACT_UPDATE: state_reg <= S_LOAD;
                        cep_pkg::ACT_SET_ALL: begin
                            // start a new move for every active joint
                            for (int i = 0; i < ACTIVE; i++) begin
                                t0_reg[i]    <= now_reg;
                                begin_reg[i] <= cur_reg[i];
                                tgt_reg[i]   <= clamp_angle(new_tgt_reg[i]);
                            end
                            state_reg <= S_LOAD;
                        end
                        cep_pkg::ACT_SET_ONE: begin
                            if (sel_ok) begin
                                tgt_reg[sel_idx] <= ang_clamped;
                                cur_reg[sel_idx] <= ang_clamped;
                            end
                            state_reg <= S_FINISH;
                        end
                        default: state_reg <= S_FINISH;
                    endcase
                end
                S_LOAD: begin
                    // skip a joint already at its target
                    if (tgt_reg[j_reg] != cur_reg[j_reg]) begin
                        neg_reg   <= tgt_reg[j_reg] < begin_reg[j_reg];
                        cmag_reg  <= (tgt_reg[j_reg] < begin_reg[j_reg])
                                   ? begin_reg[j_reg] - tgt_reg[j_reg]
                                   : tgt_reg[j_reg] - begin_reg[j_reg];
                        total_reg <= cep_pkg::TOTAL_W'((tgt_reg[j_reg] < begin_reg[j_reg])
                                   ? begin_reg[j_reg] - tgt_reg[j_reg]
                                   : tgt_reg[j_reg] - begin_reg[j_reg])
                                   * cep_pkg::TOTAL_W'(mspd_reg[j_reg]);
                        e_reg     <= now_reg - t0_reg[j_reg];
                        state_reg <= S_EVAL;
                    end else if (j_reg == JLAST) begin
                        state_reg <= S_FINISH;
                    end else begin
                        j_reg <= j_reg + 1'b1;
                    end
                end
                S_EVAL: begin
                    lo_reg <= e_twice < (TIME_WIDTH+1)'(total_reg);
                    if (snap) begin
                        cur_reg[j_reg] <= tgt_reg[j_reg];
                        if (j_reg == JLAST) begin
                            state_reg <= S_FINISH;
                        end else begin
                            j_reg     <= j_reg + 1'b1;
                            state_reg <= S_LOAD;
                        end
                    end else begin
                        state_reg <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (ease_rsp.done) begin
                        cur_reg[j_reg] <= eased[AW-1:0];
                        if (j_reg == JLAST) begin
                            state_reg <= S_FINISH;
                        end else begin
                            j_reg     <= j_reg + 1'b1;
                            state_reg <= S_LOAD;
                        end
                    end
                end
                S_FINISH: begin
                    // hold until the output register is free
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg  <= {7'b0, result};
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        ease_rsp.done |-> state_reg == S_WAIT)
        else $error("ease result arrived outside the wait step");

    a_result_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_FINISH))
        else $error("result raised outside the finish step");

    a_joint_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LOAD || state_reg == S_EVAL || state_reg == S_WAIT)
            |-> j_reg <= JLAST)
        else $error("joint index past the active joints");

endmodule

### rtl/core/cep_ease_unit.sv
// ============================================================================
// cep_ease_unit
// Shared multiply / restoring-divide engine: floor(4*c*x^3 / T^3).
// ============================================================================
module cep_ease_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  cep_pkg::ease_req_t req,
    output cep_pkg::ease_rsp_t rsp
);

    typedef enum logic [6:0] {
        E_IDLE = 7'b0000001,
        E_T2   = 7'b0000010,
        E_T3   = 7'b0000100,
        E_X2   = 7'b0001000,
        E_X3   = 7'b0010000,
        E_NUM  = 7'b0100000,
        E_DIV  = 7'b1000000
    } ease_state_t;

    ease_state_t                      state_reg, state_next;
    logic [cep_pkg::TOTAL_W-1:0]      total_reg, x_reg;
    logic [cep_pkg::ANGLE_W-1:0]      cmag_reg;
    logic [cep_pkg::CUBE_W-1:0]       cube_reg, cube_next;
    logic [cep_pkg::NUM_W-1:0]        acc_reg, acc_next;
    logic [cep_pkg::QUO_W-1:0]        quo_reg, quo_next;
    logic [2:0]                       bit_reg, bit_next;
    logic                             done_reg, done_next;

    logic [cep_pkg::MUL_A_W-1:0]      mul_a;
    logic [cep_pkg::MUL_B_W-1:0]      mul_b;
    logic [cep_pkg::MUL_A_W+cep_pkg::MUL_B_W-1:0] product;
    logic [cep_pkg::NUM_W-1:0]        trial;
    logic [cep_pkg::NUM_W:0]          diff;

    // one shared multiplier, operands chosen by step
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            E_T2: begin
                mul_a = cep_pkg::MUL_A_W'(total_reg);
                mul_b = total_reg;
            end
            E_T3: begin
                mul_a = cube_reg;
                mul_b = total_reg;
            end
            E_X2: begin
                mul_a = cep_pkg::MUL_A_W'(x_reg);
                mul_b = x_reg;
            end
            E_X3: begin
                mul_a = acc_reg[cep_pkg::MUL_A_W-1:0];
                mul_b = x_reg;
            end
            E_NUM: begin
                mul_a = acc_reg[cep_pkg::MUL_A_W-1:0];
                mul_b = cep_pkg::MUL_B_W'({cmag_reg, 2'b00});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign product = mul_a * mul_b;
    assign trial   = cep_pkg::NUM_W'(cube_reg) << bit_reg;
    assign diff    = {1'b0, acc_reg} - {1'b0, trial};

    always_comb begin
        state_next = state_reg;
        cube_next  = cube_reg;
        acc_next   = acc_reg;
        quo_next   = quo_reg;
        bit_next   = bit_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            E_IDLE: begin
                if (req.start) begin
                    state_next = E_T2;
                end
            end
            E_T2: begin
                cube_next  = product[cep_pkg::CUBE_W-1:0];
                state_next = E_T3;
            end
            E_T3: begin
                cube_next  = product[cep_pkg::CUBE_W-1:0];
                state_next = E_X2;
            end
            E_X2: begin
                acc_next   = cep_pkg::NUM_W'(product[cep_pkg::CUBE_W-1:0]);
                state_next = E_X3;
            end
            E_X3: begin
                acc_next   = cep_pkg::NUM_W'(product[cep_pkg::CUBE_W-1:0]);
                state_next = E_NUM;
            end
            E_NUM: begin
                acc_next   = product[cep_pkg::NUM_W-1:0];
                quo_next   = '0;
                bit_next   = 3'd7;
                state_next = E_DIV;
            end
            E_DIV: begin
                // restoring step: subtract the shifted divisor where it fits
                if (!diff[cep_pkg::NUM_W]) begin
                    acc_next = diff[cep_pkg::NUM_W-1:0];
                end
                quo_next = {quo_reg[cep_pkg::QUO_W-2:0], ~diff[cep_pkg::NUM_W]};
                bit_next = bit_reg - 3'd1;
                if (bit_reg == 3'd0) begin
                    done_next  = 1'b1;
                    state_next = E_IDLE;
                end
            end
            default: state_next = E_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= E_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        cube_reg <= cube_next;
        acc_reg  <= acc_next;
        quo_reg  <= quo_next;
        bit_reg  <= bit_next;
        if (state_reg == E_IDLE && req.start) begin
            total_reg <= req.total;
            x_reg     <= req.x;
            cmag_reg  <= req.cmag;
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.quo    = quo_reg;
    assign rsp.rem_nz = (acc_reg != '0);

    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg)
        else $error("ease done held longer than one cycle");

    a_done_from_div: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(done_reg) |-> $past(state_reg == E_DIV) && $past(bit_reg == 3'd0))
        else $error("ease done without a final divide step");

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> state_reg == E_IDLE)
        else $error("ease request while the unit is busy");

endmodule
